FILE: sv/ics_pkg.sv
package ics_pkg;

	localparam int CRD_W = 31;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [CRD_W-1:0] lo;
		logic [CRD_W-1:0] hi;
		logic [CNT_W-1:0] cnt;
	} seg_t;

	// outcome of laying one new interval over one open segment
	typedef struct packed {
		logic emit_en;
		seg_t emit;
		logic push0_en;
		seg_t push0;
		logic push1_en;
		seg_t push1;
	} split_t;

endpackage

FILE: sv/ics_split_unit.sv
module ics_split_unit (
	input  ics_pkg::seg_t   open_seg,
	input  ics_pkg::seg_t   req_seg,
	output ics_pkg::split_t split
);

	logic [ics_pkg::CNT_W:0] sum_w;
	logic [ics_pkg::CNT_W-1:0] sum_sat;
	logic [ics_pkg::CRD_W-1:0] s1, e1, s2, e2, e2_inc;
	logic [ics_pkg::CNT_W-1:0] c1, c2;

	assign s1 = open_seg.lo;
	assign e1 = open_seg.hi;
	assign c1 = open_seg.cnt;
	assign s2 = req_seg.lo;
	assign e2 = req_seg.hi;
	assign c2 = req_seg.cnt;
	assign e2_inc = e2 + ics_pkg::CRD_W'(1);

	assign sum_w = {1'b0, c1} + {1'b0, c2};
	assign sum_sat = sum_w[ics_pkg::CNT_W] ? ics_pkg::COUNT_MAX : sum_w[ics_pkg::CNT_W-1:0];

	always_comb begin
		split = '0;
		if (e1 < s2) begin
			// segment lies wholly before the request
			split.emit_en = 1'b1;
			split.emit = '{lo: s1, hi: e1, cnt: c1};
		end else if (s1 <= s2) begin
			split.emit_en = (s1 < s2);
			split.emit = '{lo: s1, hi: s2 - ics_pkg::CRD_W'(1), cnt: c1};
			split.push0_en = 1'b1;
			split.push0 = '{lo: s2, hi: (e1 < e2) ? e1 : e2, cnt: sum_sat};
			split.push1_en = (e2 < e1);
			split.push1 = '{lo: e2_inc, hi: e1, cnt: c1};
		end else if (e1 <= e2) begin
			split.push0_en = 1'b1;
			split.push0 = '{lo: s1, hi: e1, cnt: sum_sat};
		end else begin
			split.push0_en = (s1 <= e2);
			split.push0 = '{lo: s1, hi: e2, cnt: sum_sat};
			split.push1_en = 1'b1;
			split.push1 = '{lo: (e2_inc > s1) ? e2_inc : s1, hi: e1, cnt: c1};
		end
	end

endmodule

FILE: sv/ics_seg_store.sv
module ics_seg_store #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          rd_bank,
	input  logic [AW-1:0] rd_addr,
	output ics_pkg::seg_t rd_data,
	input  logic          wr_en,
	input  logic          wr_bank,
	input  logic [AW-1:0] wr_addr,
	input  ics_pkg::seg_t wr_data
);

	// two banks: the walk reads one and builds the next segment list in the other
	ics_pkg::seg_t bank0_q [DEPTH];
	ics_pkg::seg_t bank1_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_bank) begin
				bank1_q[wr_addr] <= wr_data;
			end else begin
				bank0_q[wr_addr] <= wr_data;
			end
		end
	end

	assign rd_data = rd_bank ? bank1_q[rd_addr] : bank0_q[rd_addr];

endmodule

FILE: sv/interval_coverage_splitter.sv
// sequence: accept the interval, a counting pass over the open segments, then a walk pass
// with an extra step per segment split in two, then a flush pass over the segments left open
// when last is set; an inverted interval skips counting and walking; each emitted segment
// may wait further on output stall
// req_stall holds off a new interval until the current one is done outside idle;
// reset clears control state, the store is garbage until written
module interval_coverage_splitter #(
	parameter int MAX_OPEN = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [ics_pkg::CRD_W-1:0] start_req,
	input  logic [ics_pkg::CRD_W-1:0] end_req,
	input  logic [ics_pkg::CNT_W-1:0] count,
	input  logic                      last,
	output logic                      seg_valid,
	input  logic                      seg_stall,
	output logic [ics_pkg::CRD_W-1:0] seg_start,
	output logic [ics_pkg::CRD_W-1:0] seg_end,
	output logic [ics_pkg::CNT_W-1:0] seg_count,
	output logic                      last_of_run,
	output logic                      overflow
);

	localparam int AW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
	localparam int UW = $clog2(MAX_OPEN + 1);
	localparam int CW = $clog2(2 * MAX_OPEN + 2);
	localparam logic [UW-1:0] MAX_U = UW'(MAX_OPEN);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_OPEN);

	ics_pkg::state_t state_q, state_d;

	// request registers
	logic [ics_pkg::CRD_W-1:0] s2_q, e2_q;
	logic [ics_pkg::CNT_W-1:0] c2_q;
	logic                      last_q;
	logic [ics_pkg::CRD_W-1:0] last_e_q;

	// control
	logic [UW-1:0] used_q, j_q, nx_q;
	logic [CW-1:0] pieces_q, nres_q, sent_q;
	logic          sub_q, bank_q, ovf_q;

	// output register
	logic                      seg_valid_q;
	ics_pkg::seg_t             out_seg_q;
	logic                      last_of_run_q, overflow_q;

	ics_pkg::seg_t  rd_seg, req_seg, push_seg, emit_seg, tail_seg;
	ics_pkg::split_t split;

	logic          req_fire, inv_req, at_end, slot_free;
	logic          emit_fire, push_en, wr_en, step_j, set_sub, swap, flush_done;
	logic [31:0]   after_w, tail_from_w;
	logic          tail_en;
	logic [CW-1:0] pieces_tot, kept;
	logic          ovf_new;

	assign req_seg = '{lo: s2_q, hi: e2_q, cnt: c2_q};

	ics_split_unit u_split (
		.open_seg (rd_seg),
		.req_seg  (req_seg),
		.split    (split)
	);

	ics_seg_store #(
		.DEPTH (MAX_OPEN),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_bank (bank_q),
		.rd_addr (j_q[AW-1:0]),
		.rd_data (rd_seg),
		.wr_en   (wr_en),
		.wr_bank (~bank_q),
		.wr_addr (nx_q[AW-1:0]),
		.wr_data (push_seg)
	);

	assign req_fire = req_valid && (state_q == ics_pkg::ST_IDLE);
	assign inv_req = (end_req < start_req);
	assign at_end = (j_q == used_q);
	assign slot_free = !seg_valid_q || !seg_stall;

	// uncovered tail of the request past the last open segment
	assign after_w = {1'b0, last_e_q} + 32'd1;
	assign tail_from_w = ((used_q != '0) && (after_w > {1'b0, s2_q})) ? after_w : {1'b0, s2_q};
	assign tail_en = (tail_from_w <= {1'b0, e2_q});
	assign tail_seg = '{lo: tail_from_w[ics_pkg::CRD_W-1:0], hi: e2_q, cnt: c2_q};

	assign pieces_tot = pieces_q + CW'(tail_en);
	assign ovf_new = (pieces_tot > MAX_C);
	assign kept = ovf_new ? MAX_C : pieces_tot;

	assign wr_en = push_en && (nx_q < MAX_U);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ics_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit_fire = 1'b0;
		emit_seg = rd_seg;
		push_en = 1'b0;
		push_seg = split.push0;
		step_j = 1'b0;
		set_sub = 1'b0;
		swap = 1'b0;
		flush_done = 1'b0;
		unique case (state_q)
			ics_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (inv_req) begin
						state_d = last ? ics_pkg::ST_FLUSH : ics_pkg::ST_IDLE;
					end else begin
						state_d = ics_pkg::ST_COUNT;
					end
				end
			end
			ics_pkg::ST_COUNT: begin
				if (at_end) begin
					state_d = ics_pkg::ST_WALK;
				end
			end
			ics_pkg::ST_WALK: begin
				if (sub_q) begin
					push_en = 1'b1;
					push_seg = split.push1;
					step_j = 1'b1;
				end else if (at_end) begin
					push_en = tail_en;
					push_seg = tail_seg;
					swap = 1'b1;
					state_d = last_q ? ics_pkg::ST_FLUSH : ics_pkg::ST_IDLE;
				end else if (!split.emit_en || slot_free) begin
					emit_fire = split.emit_en;
					emit_seg = split.emit;
					push_en = split.push0_en;
					push_seg = split.push0;
					if (split.push1_en) begin
						set_sub = 1'b1;
					end else begin
						step_j = 1'b1;
					end
				end
			end
			ics_pkg::ST_FLUSH: begin
				if (at_end) begin
					flush_done = 1'b1;
					state_d = ics_pkg::ST_IDLE;
				end else if (slot_free) begin
					emit_fire = 1'b1;
					emit_seg = rd_seg;
					step_j = 1'b1;
				end
			end
			default: begin
				state_d = ics_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			j_q <= '0;
			nx_q <= '0;
			pieces_q <= '0;
			nres_q <= '0;
			sent_q <= '0;
			sub_q <= 1'b0;
			bank_q <= 1'b0;
			ovf_q <= 1'b0;
			seg_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				j_q <= '0;
				sub_q <= 1'b0;
				nx_q <= '0;
				pieces_q <= '0;
				sent_q <= '0;
				nres_q <= (inv_req && last) ? CW'(used_q) : '0;
			end
			if (state_q == ics_pkg::ST_COUNT) begin
				if (!at_end) begin
					pieces_q <= pieces_q + CW'(split.push0_en) + CW'(split.push1_en);
					nres_q <= nres_q + CW'(split.emit_en);
					j_q <= j_q + UW'(1);
				end else begin
					j_q <= '0;
					ovf_q <= ovf_q | ovf_new;
					nres_q <= nres_q + (last_q ? kept : '0);
				end
			end
			if (step_j) begin
				j_q <= j_q + UW'(1);
				sub_q <= 1'b0;
			end
			if (set_sub) begin
				sub_q <= 1'b1;
			end
			if (wr_en) begin
				nx_q <= nx_q + UW'(1);
			end
			if (swap) begin
				bank_q <= ~bank_q;
				used_q <= nx_q + UW'(wr_en);
				j_q <= '0;
			end
			if (flush_done) begin
				used_q <= '0;
				ovf_q <= 1'b0;
			end
			if (emit_fire) begin
				sent_q <= sent_q + CW'(1);
				seg_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			s2_q <= start_req;
			e2_q <= end_req;
			c2_q <= count;
			last_q <= last;
		end
		if ((state_q == ics_pkg::ST_COUNT) && !at_end) begin
			last_e_q <= rd_seg.hi;
		end
		if (emit_fire) begin
			out_seg_q <= emit_seg;
			last_of_run_q <= ((sent_q + CW'(1)) == nres_q);
			overflow_q <= ovf_q;
		end
	end

	assign req_stall = (state_q != ics_pkg::ST_IDLE);
	assign seg_valid = seg_valid_q;
	assign seg_start = out_seg_q.lo;
	assign seg_end = out_seg_q.hi;
	assign seg_count = out_seg_q.cnt;
	assign last_of_run = last_of_run_q;
	assign overflow = overflow_q;

endmodule

FILE: tb/sv/tb_interval_coverage_splitter.sv
module tb_interval_coverage_splitter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OPEN_DEPTH = 16;
	localparam logic [ics_pkg::CRD_W-1:0] CRD_TOP = '1;
	localparam longint unsigned CRD_LIMIT = 64'h7FFF_FFFF;

	typedef enum logic [1:0] {
		ROW_MODEL,
		ROW_QUIET,
		ROW_SINGLE
	} row_kind_t;

	typedef struct packed {
		ics_pkg::seg_t seg;
		logic          fin;
		logic          ovf;
	} seg_result_t;

	typedef struct packed {
		logic [ics_pkg::CRD_W-1:0] req_lo;
		logic [ics_pkg::CRD_W-1:0] req_hi;
		logic [ics_pkg::CNT_W-1:0] req_cnt;
		logic                      req_last;
		row_kind_t                 kind;
		seg_result_t               want;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic [ics_pkg::CRD_W-1:0] start_req = '0;
	logic [ics_pkg::CRD_W-1:0] end_req = '0;
	logic [ics_pkg::CNT_W-1:0] count = '0;
	logic                      last = 1'b0;
	logic                      seg_valid;
	logic                      seg_stall = 1'b0;
	logic [ics_pkg::CRD_W-1:0] seg_start;
	logic [ics_pkg::CRD_W-1:0] seg_end;
	logic [ics_pkg::CNT_W-1:0] seg_count;
	logic                      last_of_run;
	logic                      overflow;

	// shadow of the open segment store
	ics_pkg::seg_t open_seg[OPEN_DEPTH];
	int            open_n = 0;
	logic          drop_flag = 1'b0;
	ics_pkg::seg_t next_seg[OPEN_DEPTH];
	int            next_n = 0;
	seg_result_t   fresh_segs[$];
	seg_result_t   awaited_segs[$];

	int errors = 0;
	bit calm = 1'b0;
	bit stall_bursts = 1'b1;
	int stall_left = 0;

	interval_coverage_splitter #(
		.MAX_OPEN(OPEN_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.start_req(start_req),
		.end_req(end_req),
		.count(count),
		.last(last),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_start(seg_start),
		.seg_end(seg_end),
		.seg_count(seg_count),
		.last_of_run(last_of_run),
		.overflow(overflow)
	);

	always #1 clk = ~clk;

	function automatic void close_seg(logic [ics_pkg::CRD_W-1:0] lo,
			logic [ics_pkg::CRD_W-1:0] hi, logic [ics_pkg::CNT_W-1:0] cnt);
		seg_result_t r;
		r = '0;
		r.seg.lo = lo;
		r.seg.hi = hi;
		r.seg.cnt = cnt;
		fresh_segs.push_back(r);
	endfunction

	function automatic void keep_piece(logic [ics_pkg::CRD_W-1:0] lo,
			logic [ics_pkg::CRD_W-1:0] hi, logic [ics_pkg::CNT_W-1:0] cnt);
		if (next_n >= OPEN_DEPTH) begin
			drop_flag = 1'b1;
		end else begin
			next_seg[next_n] = '{lo, hi, cnt};
			next_n++;
		end
	endfunction

	// lays one interval over the open store, collects finalized segments in fresh_segs
	function automatic void sweep_interval(logic [ics_pkg::CRD_W-1:0] s2,
			logic [ics_pkg::CRD_W-1:0] e2, logic [ics_pkg::CNT_W-1:0] c2, logic flush);
		ics_pkg::seg_t           cur;
		logic [ics_pkg::CNT_W:0] sum;
		logic [ics_pkg::CRD_W:0] tail_from;
		logic [ics_pkg::CRD_W:0] after;
		logic [ics_pkg::CRD_W:0] past_e2;
		fresh_segs.delete();
		if (e2 >= s2) begin
			next_n = 0;
			tail_from = {1'b0, s2};
			past_e2 = {1'b0, e2} + 1'b1;
			for (int j = 0; j < open_n; j++) begin
				cur = open_seg[j];
				sum = {1'b0, cur.cnt} + {1'b0, c2};
				if (sum > {1'b0, ics_pkg::COUNT_MAX})
					sum = {1'b0, ics_pkg::COUNT_MAX};
				if (cur.hi < s2) begin
					close_seg(cur.lo, cur.hi, cur.cnt);
				end else if (cur.lo <= s2) begin
					if (cur.lo < s2)
						close_seg(cur.lo, s2 - 1'b1, cur.cnt);
					keep_piece(s2, (cur.hi < e2) ? cur.hi : e2, sum[ics_pkg::CNT_W-1:0]);
					if (e2 < cur.hi)
						keep_piece(past_e2[ics_pkg::CRD_W-1:0], cur.hi, cur.cnt);
				end else if (cur.hi <= e2) begin
					keep_piece(cur.lo, cur.hi, sum[ics_pkg::CNT_W-1:0]);
				end else begin
					if (cur.lo <= e2)
						keep_piece(cur.lo, e2, sum[ics_pkg::CNT_W-1:0]);
					keep_piece((past_e2 > {1'b0, cur.lo}) ? past_e2[ics_pkg::CRD_W-1:0] : cur.lo,
						cur.hi, cur.cnt);
				end
			end
			// uncovered tail only past the end of the last open segment
			if (open_n > 0) begin
				after = {1'b0, open_seg[open_n-1].hi} + 1'b1;
				if (after > tail_from)
					tail_from = after;
			end
			if (tail_from <= {1'b0, e2})
				keep_piece(tail_from[ics_pkg::CRD_W-1:0], e2, c2);
			for (int j = 0; j < next_n; j++)
				open_seg[j] = next_seg[j];
			open_n = next_n;
		end
		if (flush) begin
			for (int j = 0; j < open_n; j++)
				close_seg(open_seg[j].lo, open_seg[j].hi, open_seg[j].cnt);
			open_n = 0;
		end
		foreach (fresh_segs[j]) begin
			fresh_segs[j].ovf = drop_flag;
			fresh_segs[j].fin = (j == fresh_segs.size() - 1);
		end
		if (flush)
			drop_flag = 1'b0;
	endfunction

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_interval(logic [ics_pkg::CRD_W-1:0] lo, logic [ics_pkg::CRD_W-1:0] hi,
			logic [ics_pkg::CNT_W-1:0] cnt, logic fin, row_kind_t kind, seg_result_t want,
			bit gaps);
		req_valid <= 1'b1;
		start_req <= lo;
		end_req <= hi;
		count <= cnt;
		last <= fin;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sweep_interval(lo, hi, cnt, fin);
		case (kind)
			ROW_MODEL: begin
				foreach (fresh_segs[j])
					awaited_segs.push_back(fresh_segs[j]);
			end
			ROW_SINGLE: begin
				awaited_segs.push_back(want);
			end
			default: begin
			end
		endcase
		if (gaps && !calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_bursts <= !stall_bursts;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_bursts && !calm && $urandom_range(0, 5) == 0) begin
			seg_stall <= 1'b1;
			stall_left <= $urandom_range(1, 13) - 1;
		end else begin
			seg_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		seg_result_t want;
		if (arst_n && seg_valid && !seg_stall) begin
			if (awaited_segs.size() == 0) begin
				errors++;
				$display("%0t: expected no segment, actual %0h..%0h count %0h", $time,
					seg_start, seg_end, seg_count);
			end else begin
				want = awaited_segs.pop_front();
				match_field("seg_start", 32'(want.seg.lo), 32'(seg_start));
				match_field("seg_end", 32'(want.seg.hi), 32'(seg_end));
				match_field("seg_count", 32'(want.seg.cnt), 32'(seg_count));
				match_field("last_of_run", 32'(want.fin), 32'(last_of_run));
				match_field("overflow", 32'(want.ovf), 32'(overflow));
			end
		end
	end

	initial begin
		stim_row_t                 plan[25];
		longint unsigned           cursor;
		longint unsigned           s_l;
		longint unsigned           e_l;
		int                        step_max;
		int                        len_max;
		int                        list_len;
		int                        noise;
		int                        taken;
		bit                        gaps;
		logic [ics_pkg::CNT_W-1:0] cnt;

		plan[0] = '{31'd0, 31'd0, 16'd0, 1'b1, ROW_SINGLE,
			'{'{31'd0, 31'd0, 16'd0}, 1'b1, 1'b0}};
		plan[1] = '{CRD_TOP, CRD_TOP, 16'hFFFF, 1'b1, ROW_SINGLE,
			'{'{CRD_TOP, CRD_TOP, 16'hFFFF}, 1'b1, 1'b0}};
		// inverted interval on an empty store, flush gives nothing
		plan[2] = '{31'd10, 31'd5, 16'd3, 1'b1, ROW_QUIET, '0};
		plan[3] = '{31'd0, CRD_TOP, 16'hFFFF, 1'b0, ROW_MODEL, '0};
		plan[4] = '{31'd5, 31'd20, 16'd1, 1'b0, ROW_MODEL, '0};
		// interval inside the first open segment
		plan[5] = '{31'd3, 31'd4, 16'd7, 1'b0, ROW_MODEL, '0};
		plan[6] = '{31'd20, 31'd0, 16'd1, 1'b1, ROW_MODEL, '0};
		// nested intervals grow the store by one each until it overflows
		for (int k = 0; k < 17; k++)
			plan[7 + k] = '{ics_pkg::CRD_W'(100), ics_pkg::CRD_W'(100 + k),
				ics_pkg::CNT_W'(k + 1), k == 16, ROW_MODEL, '0};
		// drop flag must be clear again after the flush
		plan[24] = '{31'd0, 31'd3, 16'd2, 1'b1, ROW_SINGLE,
			'{'{31'd0, 31'd3, 16'd2}, 1'b1, 1'b0}};

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_interval(plan[i].req_lo, plan[i].req_hi, plan[i].req_cnt, plan[i].req_last,
				plan[i].kind, plan[i].want, 1'b1);

		taken = 0;
		while (taken < 500) begin
			calm = (taken >= 440);
			list_len = $urandom_range(1, 30);
			gaps = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 2))
				0: begin
					cursor = $urandom_range(0, 2000);
				end
				1: begin
					cursor = longint'($urandom) & CRD_LIMIT;
				end
				default: begin
					cursor = CRD_LIMIT - $urandom_range(0, 3000);
				end
			endcase
			// dense lists pile up overlaps and overflow the store
			if ($urandom_range(0, 1) == 0) begin
				step_max = 2;
				len_max = 40;
			end else begin
				step_max = 60;
				len_max = 30;
			end
			for (int k = 0; k < list_len; k++) begin
				noise = $urandom_range(0, 19);
				s_l = cursor + $urandom_range(0, step_max);
				if (s_l > CRD_LIMIT)
					s_l = CRD_LIMIT;
				if (noise == 1) begin
					s_l = cursor - ((cursor < 60) ? cursor : longint'($urandom_range(1, 60)));
				end
				e_l = s_l + $urandom_range(0, len_max);
				if (e_l > CRD_LIMIT)
					e_l = CRD_LIMIT;
				if (noise == 0) begin
					if (s_l == 0)
						s_l = 1;
					e_l = s_l - 1 - (longint'($urandom) % s_l);
				end else if (noise != 1) begin
					cursor = s_l;
				end
				case ($urandom_range(0, 7))
					0: begin
						cnt = ics_pkg::CNT_W'($urandom);
					end
					1: begin
						cnt = 16'hFFFF - ics_pkg::CNT_W'($urandom_range(0, 40));
					end
					default: begin
						cnt = ics_pkg::CNT_W'($urandom_range(0, 30));
					end
				endcase
				send_interval(ics_pkg::CRD_W'(s_l), ics_pkg::CRD_W'(e_l), cnt,
					k == list_len - 1, ROW_MODEL, '0, gaps);
				if (noise != 0 || k == list_len - 1)
					taken++;
			end
		end
		calm = 1'b1;
		req_valid <= 1'b0;

		while (awaited_segs.size() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
sv/ics_pkg.sv
sv/ics_split_unit.sv
sv/ics_seg_store.sv
sv/interval_coverage_splitter.sv
tb/sv/tb_interval_coverage_splitter.sv
